// ===== rtl/queue_with_middle_insert_macros.svh =====
// assertion macros shared by the queue modules
`ifndef QUEUE_WITH_MIDDLE_INSERT_MACROS_SVH
`define QUEUE_WITH_MIDDLE_INSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QMI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define QMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qmi_pkg.sv =====
// shared types and codes for the middle-insert queue
package qmi_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned ID_W  = 32;
  localparam int unsigned LEN_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_MID  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP       = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_ALIAS = 2'd3;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;  // input transfer: latch item, start memory reads
    logic exec;     // apply update, load result register
  } ctl_cmd_t;

endpackage

// ===== rtl/qmi_ctrl.sv =====
// controller: two-state sequencer and output valid register
`include "queue_with_middle_insert_macros.svh"

module qmi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmi_pkg::ctl_cmd_t cmd_o
);
  import qmi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        // result register is free or drains on this edge
        in_ready_o    = !out_valid_q || out_ready_i;
        cmd_o.capture = in_valid_i && in_ready_o;
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `QMI_ASSERT_NEXT(a_exec_follows_capture, cmd_o.capture, state_q == S_EXEC, "no exec after capture")
  `QMI_ASSERT(a_valid_from_exec, $rose(out_valid_q), $past(state_q) == S_EXEC, "valid without exec")
  `QMI_ASSERT(a_no_overwrite, state_q == S_EXEC, !out_valid_q, "exec over pending result")

endmodule

// ===== rtl/qmi_dpath.sv =====
// datapath: two ring-buffer halves, pointers, counts and result register
`include "queue_with_middle_insert_macros.svh"

module qmi_dpath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qmi_pkg::ctl_cmd_t           cmd_i,
  input  logic [qmi_pkg::OP_W-1:0]    opcode_i,
  input  logic [qmi_pkg::ID_W-1:0]    item_id_i,
  output logic [1:0]                  status_o,
  output logic [qmi_pkg::ID_W-1:0]    popped_id_o,
  output logic [qmi_pkg::LEN_W-1:0]   queue_length_o
);
  import qmi_pkg::*;

  localparam int unsigned HalfDepth = (CAPACITY + 1) / 2;
  localparam int unsigned IDX_W     = (HalfDepth > 1) ? $clog2(HalfDepth) : 1;
  localparam int unsigned CNT_W     = $clog2(HalfDepth + 1);
  localparam int unsigned SUM_W     = CNT_W + 1;

  logic [ID_W-1:0] front_mem [HalfDepth];
  logic [ID_W-1:0] back_mem  [HalfDepth];

  logic [IDX_W-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CNT_W-1:0] fc_q, fc_d, bc_q, bc_d;

  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] id_q;
  logic [ID_W-1:0] front_rd_q, back_rd_q;

  status_e         status_q, res_status;
  logic [ID_W-1:0] popped_q, res_popped;
  logic [SUM_W-1:0] len_q, res_len;

  logic             fw_en, bw_en;
  logic [IDX_W-1:0] fw_addr, bw_addr;
  logic [ID_W-1:0]  fw_data, bw_data;

  logic [SUM_W-1:0] total;
  logic             full;
  logic             balanced;
  logic [IDX_W-1:0] fh_fc, bh_bc, fh_p1, bh_p1, bh_m1;

  // one conditional subtract keeps a position below the half depth
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (s >= SUM_W'(HalfDepth)) begin
      r = s - SUM_W'(HalfDepth);
    end
    return r[IDX_W-1:0];
  endfunction

  assign total = SUM_W'(fc_q) + SUM_W'(bc_q);
  assign full  = total >= SUM_W'(CAPACITY);
  assign fh_fc = ring_wrap(SUM_W'(fh_q) + SUM_W'(fc_q));
  assign bh_bc = ring_wrap(SUM_W'(bh_q) + SUM_W'(bc_q));
  assign fh_p1 = ring_wrap(SUM_W'(fh_q) + SUM_W'(1));
  assign bh_p1 = ring_wrap(SUM_W'(bh_q) + SUM_W'(1));
  assign bh_m1 = (bh_q == '0) ? IDX_W'(HalfDepth - 1) : bh_q - IDX_W'(1);

  assign balanced = (fc_q == bc_q) || (SUM_W'(fc_q) == SUM_W'(bc_q) + SUM_W'(1));

  always_comb begin
    fh_d       = fh_q;
    fc_d       = fc_q;
    bh_d       = bh_q;
    bc_d       = bc_q;
    fw_en      = 1'b0;
    fw_addr    = fh_fc;
    fw_data    = id_q;
    bw_en      = 1'b0;
    bw_addr    = bh_bc;
    bw_data    = id_q;
    res_status = ST_INSERTED;
    res_popped = '0;
    res_len    = total;
    if (cmd_i.exec) begin
      unique case (op_q) inside
        OP_POP, OP_POP_ALIAS: begin
          if (total == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_status = ST_POPPED;
            res_popped = front_rd_q;
            res_len    = total - SUM_W'(1);
            fh_d       = fh_p1;
            if (fc_q == bc_q) begin
              // back head moves across to refill the front half
              fw_en   = 1'b1;
              fw_data = back_rd_q;
              bh_d    = bh_p1;
              bc_d    = bc_q - CNT_W'(1);
            end else begin
              fc_d = fc_q - CNT_W'(1);
            end
          end
        end
        OP_PUSH_TAIL: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            res_len = total + SUM_W'(1);
            if (fc_q == '0) begin
              fw_en = 1'b1;
              fc_d  = fc_q + CNT_W'(1);
            end else if (fc_q == bc_q) begin
              fw_en   = 1'b1;
              fw_data = back_rd_q;
              bw_en   = 1'b1;
              bh_d    = bh_p1;
              fc_d    = fc_q + CNT_W'(1);
            end else begin
              bw_en = 1'b1;
              bc_d  = bc_q + CNT_W'(1);
            end
          end
        end
        OP_PUSH_MID: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            res_len = total + SUM_W'(1);
            if (fc_q == bc_q) begin
              fw_en = 1'b1;
              fc_d  = fc_q + CNT_W'(1);
            end else begin
              bw_en   = 1'b1;
              bw_addr = bh_m1;
              bh_d    = bh_m1;
              bc_d    = bc_q + CNT_W'(1);
            end
          end
        end
        default: res_status = ST_INSERTED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      fc_q <= '0;
      bh_q <= '0;
      bc_q <= '0;
    end else begin
      fh_q <= fh_d;
      fc_q <= fc_d;
      bh_q <= bh_d;
      bc_q <= bc_d;
    end
  end

  // both heads are read on the input transfer and used in the following execute cycle
  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      front_mem[fw_addr] <= fw_data;
    end
    if (cmd_i.capture) begin
      front_rd_q <= front_mem[fh_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bw_en) begin
      back_mem[bw_addr] <= bw_data;
    end
    if (cmd_i.capture) begin
      back_rd_q <= back_mem[bh_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      id_q <= item_id_i;
    end
    if (cmd_i.exec) begin
      status_q <= res_status;
      popped_q <= res_popped;
      len_q    <= res_len;
    end
  end

  assign status_o       = status_q;
  assign popped_id_o    = popped_q;
  assign queue_length_o = LEN_W'(len_q);

  `QMI_ASSERT(a_balance, 1'b1, balanced, "halves out of balance")
  `QMI_ASSERT(a_capacity, 1'b1, total <= SUM_W'(CAPACITY), "length above capacity")
  `QMI_ASSERT_NEXT(a_idle_holds, !cmd_i.exec, $stable(total), "length changed outside exec")

endmodule

// ===== rtl/queue_with_middle_insert.sv =====
// the result is valid once the execute state has loaded the result register
// no new item is taken while the execute state runs; each half's memory port is read on
// the transfer cycle and written on the following execute cycle
// a new item is taken only when the result register is empty or drains on that edge
// reset: heads, counts and control cleared at once; stores are not cleared
// top level: queue with middle insertion, two balanced ring-buffer halves
module queue_with_middle_insert #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [qmi_pkg::OP_W-1:0]    opcode_i,
  input  logic [qmi_pkg::ID_W-1:0]    item_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [qmi_pkg::ID_W-1:0]    popped_id_o,
  output logic [qmi_pkg::LEN_W-1:0]   queue_length_o
);
  import qmi_pkg::*;

  ctl_cmd_t cmd;

  qmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  qmi_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .item_id_i      (item_id_i),
    .status_o       (status_o),
    .popped_id_o    (popped_id_o),
    .queue_length_o (queue_length_o)
  );

endmodule
